// ===== hw/rtl/int32_to_decimal_ascii_macros.svh =====
// Assertion macros for the int32 to decimal ASCII converter checks.
`ifndef INT32_TO_DECIMAL_ASCII_MACROS_SVH
`define INT32_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define I2DA_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define I2DA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/i2da_pkg.sv =====
// Shared types and constants for the int32 to decimal ASCII converter.
package i2da_pkg;

   localparam int VALUE_W = 32;
   localparam int CHAR_W  = 7;
   localparam int POS_W   = 4;
   localparam int DIG_W   = 4;
   localparam int THR_W   = 34;

   localparam logic [CHAR_W-1:0] ASCII_MINUS = 7'd45;
   localparam logic [CHAR_W-1:0] ASCII_ZERO  = 7'd48;

   localparam logic [THR_W-1:0] POW10 [10] = '{
      34'd1, 34'd10, 34'd100, 34'd1000, 34'd10000, 34'd100000,
      34'd1000000, 34'd10000000, 34'd100000000, 34'd1000000000
   };

   // classified item: sign, magnitude and index of the leading digit
   typedef struct packed {
      logic               neg;
      logic [VALUE_W-1:0] mag;
      logic [DIG_W-1:0]   top;
   } entry_type;

endpackage

// ===== hw/rtl/i2da_req_if.sv =====
// Input channel: one signed 32-bit value per transfer.
interface i2da_req_if;
   import i2da_pkg::*;

   logic                      valid;
   logic                      ready;
   logic signed [VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

// ===== hw/rtl/i2da_rsp_if.sv =====
// Result channel: one ASCII character with position and last mark per transfer.
interface i2da_rsp_if;
   import i2da_pkg::*;

   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] char_code;
   logic [POS_W-1:0]  position;
   logic              is_last;

   modport source (output valid, output char_code, output position, output is_last,
                   input ready);
   modport sink (input valid, input char_code, input position, input is_last,
                 output ready);
endinterface

// ===== hw/rtl/i2da_front.sv =====
// Front end: takes values, forms sign, magnitude and leading digit index.
module i2da_front (
   input  logic                clock,
   input  logic                reset,
   i2da_req_if.sink            req,
   output logic                push_valid,
   input  logic                push_ready,
   output i2da_pkg::entry_type push_entry
);
   import i2da_pkg::*;

   logic                      hold_valid_ff, hold_valid_in;
   logic signed [VALUE_W-1:0] hold_value_ff, hold_value_in;
   logic [VALUE_W-1:0]        mag;
   logic [DIG_W-1:0]          top;
   logic                      take;

   assign req.ready = !hold_valid_ff || push_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      hold_value_in = hold_value_ff;
      if (take) begin
         hold_valid_in = 1'b1;
         hold_value_in = req.value;
      end else if (push_ready) begin
         hold_valid_in = 1'b0;
      end
   end

   always_comb begin
      mag = hold_value_ff[VALUE_W-1] ? (VALUE_W'(0) - hold_value_ff) : hold_value_ff;
      top = '0;
      for (int i = 1; i < 10; i++) begin
         if (mag >= POW10[i][VALUE_W-1:0]) begin
            top = DIG_W'(i);
         end
      end
   end

   assign push_valid     = hold_valid_ff;
   assign push_entry.neg = hold_value_ff[VALUE_W-1];
   assign push_entry.mag = mag;
   assign push_entry.top = top;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
      hold_value_ff <= hold_value_in;
   end
endmodule

// ===== hw/rtl/i2da_queue.sv =====
// Two-entry queue between the front end and the digit engine.
module i2da_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  i2da_pkg::entry_type in_entry,
   output logic                out_valid,
   input  logic                out_ready,
   output i2da_pkg::entry_type out_entry
);
   import i2da_pkg::*;

   entry_type  slots_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_entry = slots_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slots_ff[wr_ptr_ff] <= in_entry;
      end
   end
endmodule

// ===== hw/rtl/i2da_back.sv =====
// Digit engine: emits the sign of a negative value and one decimal digit per cycle while rsp is not stalled, MSD first.
module i2da_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  i2da_pkg::entry_type pop_entry,
   i2da_rsp_if.source          rsp
);
   import i2da_pkg::*;

   logic               busy_ff, busy_in;
   logic               neg_pend_ff, neg_pend_in;
   logic [VALUE_W-1:0] rem_ff, rem_in;
   logic [DIG_W-1:0]   k_ff, k_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic               out_valid_ff, out_valid_in;
   logic [CHAR_W-1:0]  out_char_ff, out_char_in;
   logic [POS_W-1:0]   out_pos_ff, out_pos_in;
   logic               out_last_ff, out_last_in;

   logic               emit_ok, step, last_digit, pop;
   logic [THR_W-1:0]   thr, sub;
   logic [DIG_W-1:0]   digit;

   assign emit_ok    = !out_valid_ff || rsp.ready;
   assign step       = busy_ff && emit_ok;
   assign last_digit = !neg_pend_ff && (k_ff == '0);
   assign pop        = pop_valid && (!busy_ff || (step && last_digit));
   assign pop_ready  = !busy_ff || (step && last_digit);

   // digit = largest j with rem >= j * 10^k
   always_comb begin
      digit = '0;
      sub   = '0;
      thr   = '0;
      for (int j = 1; j < 10; j++) begin
         thr = POW10[k_ff] * THR_W'(j);
         if ({2'b00, rem_ff} >= thr) begin
            digit = DIG_W'(j);
            sub   = thr;
         end
      end
   end

   always_comb begin
      busy_in      = busy_ff;
      neg_pend_in  = neg_pend_ff;
      rem_in       = rem_ff;
      k_in         = k_ff;
      pos_in       = pos_ff;
      out_char_in  = out_char_ff;
      out_pos_in   = out_pos_ff;
      out_last_in  = out_last_ff;
      out_valid_in = out_valid_ff;

      if (rsp.ready) begin
         out_valid_in = 1'b0;
      end

      if (step) begin
         out_valid_in = 1'b1;
         out_pos_in   = pos_ff;
         pos_in       = pos_ff + POS_W'(1);
         if (neg_pend_ff) begin
            neg_pend_in = 1'b0;
            out_char_in = ASCII_MINUS;
            out_last_in = 1'b0;
         end else begin
            out_char_in = ASCII_ZERO + CHAR_W'(digit);
            out_last_in = (k_ff == '0);
            rem_in      = rem_ff - sub[VALUE_W-1:0];
            k_in        = k_ff - DIG_W'(1);
            if (k_ff == '0) begin
               busy_in = 1'b0;
            end
         end
      end

      if (pop) begin
         busy_in     = 1'b1;
         neg_pend_in = pop_entry.neg;
         rem_in      = pop_entry.mag;
         k_in        = pop_entry.top;
         pos_in      = '0;
      end
   end

   assign rsp.valid     = out_valid_ff;
   assign rsp.char_code = out_char_ff;
   assign rsp.position  = out_pos_ff;
   assign rsp.is_last   = out_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
      neg_pend_ff <= neg_pend_in;
      rem_ff      <= rem_in;
      k_ff        <= k_in;
      pos_ff      <= pos_in;
      out_char_ff <= out_char_in;
      out_pos_ff  <= out_pos_in;
      out_last_ff <= out_last_in;
   end
endmodule

// ===== hw/rtl/int32_to_decimal_ascii.sv =====
// Top level: signed 32-bit integer to decimal ASCII character stream.
//
// req_ch carries one signed 32-bit value per transfer. rsp_ch returns its
// decimal text one character per transfer, most significant first: a '-'
// for negative values, then 1 to 10 digits. Each character carries its
// buffer position (from 0) and is_last on the final digit.
// Path: a value goes through the front end's holding register, the queue
// and the digit engine's state, then each character through the output register.
// Throughput: one character per cycle while rsp_ch.ready is high, with no
// gap between values; a value has 1 to 11 characters. The digit engine,
// which resolves one decimal digit per cycle, sets this figure.
// The front end holds one value and the queue two more, so req_ch keeps
// taking values while the digit engine works.
// Reset (synchronous, active high) empties the holding register, the queue
// and the output register; no value or character survives it.
// When the receiver holds rsp_ch.ready low, the shown character stays put,
// the engine stops, and req_ch backs up once the queue fills.
module int32_to_decimal_ascii (
   input  logic       clock,
   input  logic       reset,
   i2da_req_if.sink   req_ch,
   i2da_rsp_if.source rsp_ch
);
   import i2da_pkg::*;

   logic      push_valid, push_ready;
   entry_type push_entry;
   logic      pop_valid, pop_ready;
   entry_type pop_entry;

   i2da_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   i2da_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (push_valid),
      .in_ready  (push_ready),
      .in_entry  (push_entry),
      .out_valid (pop_valid),
      .out_ready (pop_ready),
      .out_entry (pop_entry)
   );

   i2da_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_entry (pop_entry),
      .rsp       (rsp_ch)
   );
endmodule

// ===== hw/rtl/i2da_checker.sv =====
// Port-level checks for the converter and their bind to the top level.
`include "int32_to_decimal_ascii_macros.svh"

module i2da_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [6:0] rsp_char_code,
   input logic [3:0] rsp_position,
   input logic       rsp_is_last
);
   import i2da_pkg::*;

   `I2DA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_char_code) && $stable(rsp_position) && $stable(rsp_is_last), "stalled transfer changed")
   `I2DA_ASSERT_NOW(a_minus_first, clock, reset, rsp_valid && rsp_char_code == ASCII_MINUS, rsp_position == '0 && !rsp_is_last, "minus sign not leading")
   `I2DA_ASSERT_NOW(a_digit_code, clock, reset, rsp_valid && rsp_char_code != ASCII_MINUS, rsp_char_code >= ASCII_ZERO && rsp_char_code <= ASCII_ZERO + 7'd9, "bad digit code")
   `I2DA_ASSERT_NOW(a_pos_range, clock, reset, rsp_valid, rsp_position <= 4'd10, "position out of range")
endmodule

bind int32_to_decimal_ascii i2da_checker u_i2da_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_ch.valid),
   .rsp_ready     (rsp_ch.ready),
   .rsp_char_code (rsp_ch.char_code),
   .rsp_position  (rsp_ch.position),
   .rsp_is_last   (rsp_ch.is_last)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for int32_to_decimal_ascii: random and directed values, text check.
module tb_top;
   import i2da_pkg::*;

   localparam int RADIX         = 10;
   localparam int RANDOM_ITEMS  = 430;
   localparam int SETTLE_CYCLES = 20;
   localparam int DIRECTED_N    = 20;

   localparam logic signed [VALUE_W-1:0] DIRECTED [DIRECTED_N] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, -32'sd9, 32'sd10, -32'sd10, 32'sd99,
      32'sd100, -32'sd100, 32'sd12345, 32'sd999999999, 32'sd1000000000,
      -32'sd1000000000, 32'sd1234567890, -32'sd1234567890, 32'sh7FFFFFFF,
      32'sh80000001, 32'sh80000000, 32'sd7
   };

   typedef struct {
      logic signed [VALUE_W-1:0] value;
      int                        gap;
      bit                        drain;
   } send_item_type;

   typedef struct packed {
      logic [CHAR_W-1:0] char_code;
      logic [POS_W-1:0]  position;
      logic              is_last;
   } text_char_type;

   logic clock;
   logic reset;

   i2da_req_if req_ch ();
   i2da_rsp_if rsp_ch ();

   int32_to_decimal_ascii u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   send_item_type send_queue[$];
   text_char_type expected_text[$];
   int            values_taken;
   int            chars_due;
   int            chars_seen;
   int            error_count;
   int            rsp_stall;
   int            cycle_count;
   bit            rsp_steady;

   // decimal text of one value, appended to the expected stream; returns its length
   function automatic int predict_text(logic signed [VALUE_W-1:0] value);
      logic [VALUE_W-1:0] mag;
      logic [DIG_W-1:0]   digits[$];
      text_char_type      ch;
      int                 pos;
      pos = 0;
      mag = value;
      if (value[VALUE_W-1]) mag = ~mag + 1'b1;
      do begin
         digits.push_front(DIG_W'(mag % RADIX));
         mag = mag / RADIX;
      end while (mag != 0);
      if (value[VALUE_W-1]) begin
         ch.char_code = ASCII_MINUS;
         ch.position  = '0;
         ch.is_last   = 1'b0;
         expected_text.push_back(ch);
         pos = 1;
      end
      foreach (digits[i]) begin
         ch.char_code = ASCII_ZERO + CHAR_W'(digits[i]);
         ch.position  = POS_W'(pos);
         ch.is_last   = (i == digits.size() - 1);
         expected_text.push_back(ch);
         pos++;
      end
      return pos;
   endfunction

   function automatic int idle_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
   endfunction

   function automatic int sender_gap();
      return ($urandom_range(0, 1) == 0) ? 0 : idle_len();
   endfunction

   // mix of raw words, digit-count boundaries and values of a chosen length
   function automatic logic signed [VALUE_W-1:0] random_value();
      int unsigned lo;
      int unsigned hi;
      int unsigned mag;
      int          ndig;
      int          pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) return $urandom();
      ndig = $urandom_range(1, 10);
      lo = 1;
      repeat (ndig - 1) lo = lo * RADIX;
      hi = (ndig == 10) ? 32'h7FFFFFFF : lo * RADIX - 1;
      if (ndig == 1) lo = 0;
      if (pick < 5) mag = ($urandom_range(0, 1) == 0) ? lo : hi;
      else mag = $urandom_range(hi, lo);
      return ($urandom_range(0, 1) == 0) ? -$signed(mag) : $signed(mag);
   endfunction

   task automatic add_value(logic signed [VALUE_W-1:0] value, int gap, bit drain);
      send_item_type item;
      item.value = value;
      item.gap   = gap;
      item.drain = drain;
      send_queue.push_back(item);
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // sender
   always @(posedge clock) begin : drive_req
      int            n;
      send_item_type item;
      if (reset) begin
         req_ch.valid <= 1'b0;
         req_ch.value <= '0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            n = predict_text(req_ch.value);
            chars_due    <= chars_due + n;
            values_taken <= values_taken + 1;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (send_queue.size() == 0) begin
               req_ch.valid <= 1'b0;
            end else if (send_queue[0].gap > 0) begin
               send_queue[0].gap--;
               req_ch.valid <= 1'b0;
            end else if (send_queue[0].drain && (req_ch.valid || chars_seen != chars_due)) begin
               req_ch.valid <= 1'b0;
            end else begin
               item = send_queue.pop_front();
               req_ch.valid <= 1'b1;
               req_ch.value <= item.value;
            end
         end
      end
   end

   // receiver and checker
   always @(posedge clock) begin : watch_rsp
      text_char_type want;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else begin
         cycle_count <= cycle_count + 1;
         if (cycle_count % 256 == 0) rsp_steady <= ($urandom_range(0, 2) == 0);
         if (rsp_ch.valid && rsp_ch.ready) begin
            chars_seen <= chars_seen + 1;
            if (expected_text.size() == 0) begin
               $error("unexpected transfer: char_code %0d position %0d is_last %0d",
                      rsp_ch.char_code, rsp_ch.position, rsp_ch.is_last);
               error_count++;
            end else begin
               want = expected_text.pop_front();
               if (rsp_ch.char_code !== want.char_code) begin
                  $error("char_code: expected %0d, got %0d", want.char_code, rsp_ch.char_code);
                  error_count++;
               end
               if (rsp_ch.position !== want.position) begin
                  $error("position: expected %0d, got %0d", want.position, rsp_ch.position);
                  error_count++;
               end
               if (rsp_ch.is_last !== want.is_last) begin
                  $error("is_last: expected %0d, got %0d", want.is_last, rsp_ch.is_last);
                  error_count++;
               end
            end
         end
         if (rsp_stall > 0) begin
            rsp_stall    <= rsp_stall - 1;
            rsp_ch.ready <= 1'b0;
         end else if (!rsp_steady && $urandom_range(0, 3) == 0) begin
            rsp_stall    <= idle_len() - 1;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   initial begin
      int total;
      bit steady;
      reset = 1'b1;

      for (int k = 0; k < DIRECTED_N; k++) add_value(DIRECTED[k], 0, (k == 10));
      for (int k = 0; k < RANDOM_ITEMS; k++) begin
         if (k % 60 == 0) steady = ($urandom_range(0, 2) == 0);
         add_value(random_value(), steady ? 0 : sender_gap(), (k % 90 == 45));
      end
      total = send_queue.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (values_taken != total) @(posedge clock);
      while (chars_seen != chars_due) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_text.size() != 0) begin
         $error("%0d expected characters never arrived", expected_text.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASS int32_to_decimal_ascii");
      end else begin
         $display("FAIL int32_to_decimal_ascii");
      end
      $finish;
   end

   initial begin
      #4_000_000;
      $display("FAIL int32_to_decimal_ascii");
      $finish;
   end

endmodule
